/* hdl/bps_pkg.sv */
package bps_pkg;

    localparam int unsigned DUTY_W  = 16;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_TDATA_W = 56;
    localparam int unsigned IN_TDATA_W  = 8;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_COUNTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_DUTY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY   = 2'd3;

    localparam logic [DUTY_W-1:0]  RST_PERIOD_COUNTS = 16'd5000;
    localparam logic [DUTY_W-1:0]  RST_CHARGE_DUTY   = 16'd4500;
    localparam logic [DELAY_W-1:0] RST_INITIAL_DELAY = 16'd100;
    localparam logic [DELAY_W-1:0] RST_PHASE_DELAY   = 16'd100;

    typedef struct packed {
        logic [DUTY_W-1:0]  period_counts;
        logic [DUTY_W-1:0]  charge_duty;
        logic [DELAY_W-1:0] initial_delay;
        logic [DELAY_W-1:0] phase_delay;
    } t_cfg;

    typedef struct packed {
        logic              done_res;
        logic              charge_mode_enter;
        logic [DUTY_W-1:0] duty_c;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_a;
    } t_result;

endpackage

/* hdl/bps_cfg.sv */
module bps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [bps_pkg::DUTY_W-1:0]     i_data,
    output bps_pkg::t_cfg                  o_cfg
);

    bps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_counts <= bps_pkg::RST_PERIOD_COUNTS;
            r_cfg.charge_duty   <= bps_pkg::RST_CHARGE_DUTY;
            r_cfg.initial_delay <= bps_pkg::RST_INITIAL_DELAY;
            r_cfg.phase_delay   <= bps_pkg::RST_PHASE_DELAY;
        end else if (i_we) begin
            case (i_index)
                bps_pkg::CFG_PERIOD_COUNTS: r_cfg.period_counts <= i_data;
                bps_pkg::CFG_CHARGE_DUTY:   r_cfg.charge_duty   <= i_data;
                bps_pkg::CFG_INITIAL_DELAY: r_cfg.initial_delay <= i_data;
                bps_pkg::CFG_PHASE_DELAY:   r_cfg.phase_delay   <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/bps_core.sv */
module bps_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_restart,
    input  bps_pkg::t_cfg     i_cfg,
    output bps_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_WAIT  = 4'd1,
        PH_A_SET = 4'd2,
        PH_A_CHG = 4'd3,
        PH_B_SET = 4'd4,
        PH_B_CHG = 4'd5,
        PH_C_SET = 4'd6,
        PH_C_CHG = 4'd7,
        PH_DONE  = 4'd8
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [bps_pkg::DELAY_W-1:0] r_delay, n_delay, delay_upd;
    logic [bps_pkg::DUTY_W-1:0]  r_duty_a, n_duty_a;
    logic [bps_pkg::DUTY_W-1:0]  r_duty_b, n_duty_b;
    logic [bps_pkg::DUTY_W-1:0]  r_duty_c, n_duty_c;
    logic                        n_enter, n_done;

    always_comb begin
        n_phase   = r_phase;
        delay_upd = r_delay;
        n_duty_a  = r_duty_a;
        n_duty_b  = r_duty_b;
        n_duty_c  = r_duty_c;
        n_enter   = 1'b0;
        n_done    = 1'b0;
        n_delay   = r_delay;
        if (i_restart) begin
            n_phase  = PH_IDLE;
            n_duty_a = '0;
            n_duty_b = '0;
            n_duty_c = '0;
            n_delay  = '0;
        end else begin
            case (r_phase)
                PH_WAIT:  if (r_delay == '0) n_phase = PH_A_SET;
                PH_A_SET: begin
                    n_duty_a  = i_cfg.charge_duty;
                    n_phase   = PH_A_CHG;
                    delay_upd = i_cfg.phase_delay;
                end
                PH_A_CHG: if (r_delay == '0) n_phase = PH_B_SET;
                PH_B_SET: begin
                    n_duty_b  = i_cfg.charge_duty;
                    n_phase   = PH_B_CHG;
                    delay_upd = i_cfg.phase_delay;
                end
                PH_B_CHG: if (r_delay == '0) n_phase = PH_C_SET;
                PH_C_SET: begin
                    n_duty_c  = i_cfg.charge_duty;
                    n_phase   = PH_C_CHG;
                    delay_upd = i_cfg.phase_delay;
                end
                PH_C_CHG: if (r_delay == '0) n_phase = PH_DONE;
                PH_DONE:  n_done = 1'b1;
                default: begin
                    // idle, and any stray code, starts the sequence
                    n_enter   = 1'b1;
                    n_duty_a  = i_cfg.period_counts;
                    n_duty_b  = i_cfg.period_counts;
                    n_duty_c  = i_cfg.period_counts;
                    n_phase   = PH_WAIT;
                    delay_upd = i_cfg.initial_delay;
                end
            endcase
            n_delay = (delay_upd != '0) ?
                      delay_upd - {{(bps_pkg::DELAY_W-1){1'b0}}, 1'b1} : delay_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_delay  <= '0;
            r_duty_a <= '0;
            r_duty_b <= '0;
            r_duty_c <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_delay  <= n_delay;
            r_duty_a <= n_duty_a;
            r_duty_b <= n_duty_b;
            r_duty_c <= n_duty_c;
        end
    end

    // result for this word, registered by the top level
    always_comb begin
        o_result.duty_a            = n_duty_a;
        o_result.duty_b            = n_duty_b;
        o_result.duty_c            = n_duty_c;
        o_result.charge_mode_enter = n_enter;
        o_result.done_res          = n_done;
    end

endmodule

/* hdl/bootstrap_precharge_sequencer.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata[0] restart
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: duty_a, duty_b, duty_c, enter, done
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One word per clock while the output is not stalled: the state update and
// result are computed in the cycle a word is accepted and the result lands in
// the output register, so m_axis_tvalid rises in the cycle after the accept.
// Reset (i_rst_n low, synchronous) loads the default registers and idle phase.
// A stalled output holds its word; input is taken again as soon as it drains.
module bootstrap_precharge_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] restart, [7:1] zero
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [48] charge_mode_enter,
    // [49] done_res, [55:50] zero
    output logic [bps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bps_pkg::DUTY_W-1:0]          i_cfg_data
);

    bps_pkg::t_cfg    cfg;
    bps_pkg::t_result result;
    bps_pkg::t_result r_out;
    logic             r_out_valid;
    logic             in_acc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    bps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    bps_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (in_acc),
        .i_restart (s_axis_tdata[0]),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out};

    a_enter_done_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.charge_mode_enter && r_out.done_res))
        else $error("enter and done both set");

    a_restart_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tdata[0]) |=> (r_out_valid && r_out.duty_a == '0 &&
            r_out.duty_b == '0 && r_out.duty_c == '0 && !r_out.charge_mode_enter))
        else $error("restart word not zeroed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("output word lost under stall");

    a_enter_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.charge_mode_enter) |->
            (r_out.duty_a == r_out.duty_b && r_out.duty_b == r_out.duty_c))
        else $error("idle step duties differ");

endmodule

/* test/bootstrap_precharge_sequencer_tb.sv */
module bootstrap_precharge_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RES_W = $bits(bps_pkg::t_result);

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_INIT_WAIT,
        SEQ_A_SETUP,
        SEQ_A_CHARGE,
        SEQ_B_SETUP,
        SEQ_B_CHARGE,
        SEQ_C_SETUP,
        SEQ_C_CHARGE,
        SEQ_DONE
    } t_seq_phase;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [bps_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;   // [0] restart, [7:1] zero
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c, [48] charge_mode_enter,
    // [49] done_res, [55:50] zero
    logic [bps_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [bps_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [bps_pkg::DUTY_W-1:0]         i_cfg_data = '0;

    bootstrap_precharge_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    bps_pkg::t_cfg     cfg_model = '{bps_pkg::RST_PERIOD_COUNTS, bps_pkg::RST_CHARGE_DUTY,
                                     bps_pkg::RST_INITIAL_DELAY, bps_pkg::RST_PHASE_DELAY};
    t_seq_phase        seq_phase = SEQ_IDLE;
    logic [bps_pkg::DELAY_W-1:0] delay_cnt = '0;
    logic [bps_pkg::DUTY_W-1:0]  held_duty_a = '0;
    logic [bps_pkg::DUTY_W-1:0]  held_duty_b = '0;
    logic [bps_pkg::DUTY_W-1:0]  held_duty_c = '0;

    logic              tick_q[$];          // restart flag of each pending word
    bps_pkg::t_result  duty_expect_q[$];

    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int err_cnt = 0;
    int words_sent = 0;
    int words_checked = 0;
    int done_words = 0;
    int enter_words = 0;
    int reg_writes = 0;

    bps_pkg::t_result got_word;
    bps_pkg::t_result want_word;

    function automatic bps_pkg::t_result advance_sequence(input logic restart);
        bps_pkg::t_result r;
        r = '0;
        if (restart) begin
            seq_phase = SEQ_IDLE;
            delay_cnt = '0;
            held_duty_a = '0;
            held_duty_b = '0;
            held_duty_c = '0;
        end else begin
            case (seq_phase)
                SEQ_INIT_WAIT: if (delay_cnt == 0) seq_phase = SEQ_A_SETUP;
                SEQ_A_SETUP: begin
                    held_duty_a = cfg_model.charge_duty;
                    seq_phase = SEQ_A_CHARGE;
                    delay_cnt = cfg_model.phase_delay;
                end
                SEQ_A_CHARGE: if (delay_cnt == 0) seq_phase = SEQ_B_SETUP;
                SEQ_B_SETUP: begin
                    held_duty_b = cfg_model.charge_duty;
                    seq_phase = SEQ_B_CHARGE;
                    delay_cnt = cfg_model.phase_delay;
                end
                SEQ_B_CHARGE: if (delay_cnt == 0) seq_phase = SEQ_C_SETUP;
                SEQ_C_SETUP: begin
                    held_duty_c = cfg_model.charge_duty;
                    seq_phase = SEQ_C_CHARGE;
                    delay_cnt = cfg_model.phase_delay;
                end
                SEQ_C_CHARGE: if (delay_cnt == 0) seq_phase = SEQ_DONE;
                SEQ_DONE: r.done_res = 1'b1;
                default: begin
                    // idle tick: full period on all legs, precharge entry pulse
                    r.charge_mode_enter = 1'b1;
                    held_duty_a = cfg_model.period_counts;
                    held_duty_b = cfg_model.period_counts;
                    held_duty_c = cfg_model.period_counts;
                    seq_phase = SEQ_INIT_WAIT;
                    delay_cnt = cfg_model.initial_delay;
                end
            endcase
            if (delay_cnt != 0) delay_cnt = delay_cnt - 16'd1;
        end
        r.duty_a = held_duty_a;
        r.duty_b = held_duty_b;
        r.duty_c = held_duty_c;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] MISMATCH %s: got 0x%04h, expected 0x%04h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                duty_expect_q.push_back(advance_sequence(s_axis_tdata[0]));
                words_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(bps_pkg::IN_TDATA_W-1){1'b0}}, tick_q.pop_front()};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_word = bps_pkg::t_result'(m_axis_tdata[RES_W-1:0]);
                if (duty_expect_q.size() == 0) begin
                    report_mismatch("word with nothing expected", got_word.duty_a, '0);
                end else begin
                    want_word = duty_expect_q.pop_front();
                    words_checked++;
                    if (got_word.duty_a !== want_word.duty_a)
                        report_mismatch("duty_a", got_word.duty_a, want_word.duty_a);
                    if (got_word.duty_b !== want_word.duty_b)
                        report_mismatch("duty_b", got_word.duty_b, want_word.duty_b);
                    if (got_word.duty_c !== want_word.duty_c)
                        report_mismatch("duty_c", got_word.duty_c, want_word.duty_c);
                    if (got_word.charge_mode_enter !== want_word.charge_mode_enter)
                        report_mismatch("charge_mode_enter", 16'(got_word.charge_mode_enter),
                                        16'(want_word.charge_mode_enter));
                    if (got_word.done_res !== want_word.done_res)
                        report_mismatch("done_res", 16'(got_word.done_res),
                                        16'(want_word.done_res));
                    if (m_axis_tdata[bps_pkg::OUT_TDATA_W-1:RES_W] !== '0)
                        report_mismatch("pad bits",
                                        16'(m_axis_tdata[bps_pkg::OUT_TDATA_W-1:RES_W]), '0);
                    if (want_word.done_res) done_words++;
                    if (want_word.charge_mode_enter) enter_words++;
                end
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    task automatic write_reg(input logic [bps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bps_pkg::DUTY_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bps_pkg::CFG_PERIOD_COUNTS: cfg_model.period_counts = val;
            bps_pkg::CFG_CHARGE_DUTY:   cfg_model.charge_duty = val;
            bps_pkg::CFG_INITIAL_DELAY: cfg_model.initial_delay = val;
            bps_pkg::CFG_PHASE_DELAY:   cfg_model.phase_delay = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic write_all_regs(input logic [15:0] period, input logic [15:0] charge,
                                  input logic [15:0] init_dly, input logic [15:0] ph_dly);
        write_reg(bps_pkg::CFG_PERIOD_COUNTS, period);
        write_reg(bps_pkg::CFG_CHARGE_DUTY, charge);
        write_reg(bps_pkg::CFG_INITIAL_DELAY, init_dly);
        write_reg(bps_pkg::CFG_PHASE_DELAY, ph_dly);
    endtask

    // hold off the sender until every expected word is back
    task automatic drain_results();
        while (tick_q.size() != 0 || s_axis_tvalid || duty_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'($urandom_range(10, 40));
            2: return 16'h0000;
            default: return 16'($urandom_range(1, 5));
        endcase
    endfunction

    // one precharge run from idle, through done, closed by a restart;
    // some runs are cut short by an early restart
    function automatic int queue_sequence(input bit full_run);
        int len;
        int cut;
        len = 4 + int'(cfg_model.initial_delay) + 3 * (int'(cfg_model.phase_delay) + 2)
              + $urandom_range(0, 3);
        if (full_run) cut = len;
        else if (len > 200) cut = $urandom_range(0, 80);
        else if ($urandom_range(0, 6) == 0) cut = $urandom_range(0, len - 1);
        else cut = len;
        repeat (cut) tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        return cut + 1;
    endfunction

    function automatic int queue_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) tick_q.push_back($urandom_range(0, 2) == 0);
        return n;
    endfunction

    initial begin
        int pushed;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 12;
        sink_idle_pct = 53;

        // reset values: restart from idle, idle tick, restart mid-wait, double restart
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b1);
        tick_q.push_back(1'b0);
        drain_results();

        // extremes, zero delays: every phase advances on its next tick
        write_all_regs(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
        tick_q.push_back(1'b1);
        repeat (11) tick_q.push_back(1'b0);
        tick_q.push_back(1'b1);
        drain_results();

        // reset defaults, one complete run
        write_all_regs(bps_pkg::RST_PERIOD_COUNTS, bps_pkg::RST_CHARGE_DUTY,
                       bps_pkg::RST_INITIAL_DELAY, bps_pkg::RST_PHASE_DELAY);
        void'(queue_sequence(1'b1));
        drain_results();

        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 12 : (mode == 1) ? 53 : 0;
            sink_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 12 : 0;
            for (int k = 0; k < 4; k++) begin
                write_all_regs(pick_level(), pick_level(), pick_delay(), pick_delay());
                pushed = 0;
                while (pushed < 40) begin
                    pushed += queue_sequence(1'b0);
                    if ($urandom_range(0, 4) == 0) pushed += queue_noise();
                end
                drain_results();
            end
        end

        $display("Covered %0d input words and %0d checked result words over %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("  %0d precharge entries, %0d words in the done phase, three idle patterns",
                 enter_words, done_words);
        if (err_cnt == 0 && duty_expect_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d words still expected", duty_expect_q.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
